/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// The property must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

/* hw/rtl/cpag_pkg.sv */
// ----------------------------------------------------------------------------
// cpag_pkg
// Piece codes, ray geometry and leaper attack tables for the attack generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpag_pkg;

    localparam logic [2:0] CMD_KNIGHT = 3'd0;
    localparam logic [2:0] CMD_BISHOP = 3'd1;
    localparam logic [2:0] CMD_ROOK   = 3'd2;
    localparam logic [2:0] CMD_QUEEN  = 3'd3;
    localparam logic [2:0] CMD_KING   = 3'd4;

    localparam int DIRS  = 8;
    localparam int STEPS = 7;

    typedef struct packed {
        logic [5:0] sq;
        logic       on;
        logic       occ;
    } lane_t;

    typedef lane_t [DIRS-1:0][STEPS-1:0] lanes_t;
    typedef logic [DIRS-1:0][STEPS-1:0]  hits_t;
    typedef logic [DIRS-1:0][STEPS-1:0][5:0] lane_sq_t;

    // Diagonal directions are 0 to 3, orthogonal directions 4 to 7.
    function automatic logic signed [1:0] dir_df(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd2, 3'd6: v = 2'sd1;
            3'd1, 3'd3, 3'd7: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dr(input logic [2:0] d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd1, 3'd4: v = 2'sd1;
            3'd2, 3'd3, 3'd5: v = -2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [2:0] jump_df(input logic [2:0] j);
        logic signed [2:0] v;
        case (j)
            3'd0, 3'd3: v = 3'sd1;
            3'd1, 3'd2: v = 3'sd2;
            3'd4, 3'd7: v = -3'sd1;
            default:    v = -3'sd2;
        endcase
        return v;
    endfunction

    function automatic logic signed [2:0] jump_dr(input logic [2:0] j);
        logic signed [2:0] v;
        case (j)
            3'd0, 3'd4: v = 3'sd2;
            3'd1, 3'd5: v = 3'sd1;
            3'd2, 3'd6: v = -3'sd1;
            default:    v = -3'sd2;
        endcase
        return v;
    endfunction

    // Knight or king attack board for one square; jumps never wrap an edge.
    function automatic logic [63:0] leap_board(input logic [5:0] sq, input logic knight);
        logic [63:0] b;
        int f;
        int r;
        int nf;
        int nr;
        b = '0;
        f = int'(sq[2:0]);
        r = int'(sq[5:3]);
        for (int j = 0; j < 8; j++) begin
            if (knight) begin
                nf = f + int'(jump_df(3'(j)));
                nr = r + int'(jump_dr(3'(j)));
            end else begin
                nf = f + int'(dir_df(3'(j)));
                nr = r + int'(dir_dr(3'(j)));
            end
            if (nf >= 0 && nf <= 7 && nr >= 0 && nr <= 7) begin
                b[6'(nr * 8 + nf)] = 1'b1;
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cpag_gather.sv */
// ----------------------------------------------------------------------------
// cpag_gather
// Walks the eight rays from a square and picks up target squares and blockers.
// ----------------------------------------------------------------------------
`default_nettype none

module cpag_gather (
    input  wire logic [5:0]      square,
    input  wire logic [63:0]     occupancy,
    output cpag_pkg::lanes_t     lanes
);

    always_comb
    begin
        logic signed [4:0] s;
        logic signed [4:0] fl;
        logic signed [4:0] rl;
        logic signed [4:0] nf;
        logic signed [4:0] nr;
        logic signed [1:0] df;
        logic signed [1:0] dr;
        logic [5:0]        tsq;
        logic              on;
        lanes = '0;
        fl = $signed({2'b00, square[2:0]});
        rl = $signed({2'b00, square[5:3]});
        for (int d = 0; d < cpag_pkg::DIRS; d++) begin
            df = cpag_pkg::dir_df(3'(d));
            dr = cpag_pkg::dir_dr(3'(d));
            for (int k = 0; k < cpag_pkg::STEPS; k++) begin
                s = 5'(k + 1);
                nf = (df > 0) ? fl + s : ((df < 0) ? fl - s : fl);
                nr = (dr > 0) ? rl + s : ((dr < 0) ? rl - s : rl);
                on = (nf >= 0) && (nf <= 5'sd7) && (nr >= 0) && (nr <= 5'sd7);
                tsq = {nr[2:0], nf[2:0]};
                lanes[d][k].sq  = tsq;
                lanes[d][k].on  = on;
                lanes[d][k].occ = on && occupancy[tsq];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/chess_piece_attack_generator_top.sv */
// ----------------------------------------------------------------------------
// chess_piece_attack_generator_top
// Three-stage pipeline giving the attacked-square board of one chess piece.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Fields
//  input    in_valid / in_stall    cmd, square, occupancy
//  output   out_valid / out_stall  attacks
//
// An accepted request passes through the stage registers s1, s2 and s3 to a valid result.
// A new request is accepted every cycle while the output is not stalled.
// The stages are ray gathering, blocker cut, and board assembly.
// A stall fills empty stages first and then holds the input channel.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module chess_piece_attack_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [5:0]  square,
    input  wire logic [63:0] occupancy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      attacks
);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic ready1, ready2, ready3;

    logic [2:0]        s1_cmd_reg;
    logic [5:0]        s1_square_reg;
    cpag_pkg::lanes_t  s1_lanes_reg;
    cpag_pkg::lanes_t  lanes_next;

    logic [2:0]          s2_cmd_reg;
    logic [5:0]          s2_square_reg;
    cpag_pkg::hits_t     s2_hits_reg, hits_next;
    cpag_pkg::lane_sq_t  s2_sq_reg, sq_next;

    logic [2:0]  s3_cmd_reg;
    logic [5:0]  s3_square_reg;
    logic [63:0] attacks_reg, attacks_next;

    assign ready3 = !s3_valid_reg || !out_stall;
    assign ready2 = !s2_valid_reg || ready3;
    assign ready1 = !s1_valid_reg || ready2;
    assign in_stall = !ready1;

    assign s1_valid_next = ready1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = ready3 ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    cpag_gather u_gather (
        .square    (square),
        .occupancy (occupancy),
        .lanes     (lanes_next)
    );

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_cmd_reg    <= cmd;
            s1_square_reg <= square;
            s1_lanes_reg  <= lanes_next;
        end
    end

    // A ray keeps squares up to and including its first occupied square.
    always_comb
    begin
        logic en;
        logic blocked;
        hits_next = '0;
        sq_next   = '0;
        for (int d = 0; d < cpag_pkg::DIRS; d++) begin
            case (s1_cmd_reg)
                cpag_pkg::CMD_BISHOP: en = (d < 4);
                cpag_pkg::CMD_ROOK:   en = (d >= 4);
                cpag_pkg::CMD_QUEEN:  en = 1'b1;
                default:              en = 1'b0;
            endcase
            blocked = 1'b0;
            for (int k = 0; k < cpag_pkg::STEPS; k++) begin
                hits_next[d][k] = en && s1_lanes_reg[d][k].on && !blocked;
                sq_next[d][k]   = s1_lanes_reg[d][k].sq;
                blocked = blocked || s1_lanes_reg[d][k].occ;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_square_reg <= s1_square_reg;
            s2_hits_reg   <= hits_next;
            s2_sq_reg     <= sq_next;
        end
    end

    always_comb
    begin
        attacks_next = '0;
        for (int d = 0; d < cpag_pkg::DIRS; d++) begin
            for (int k = 0; k < cpag_pkg::STEPS; k++) begin
                if (s2_hits_reg[d][k])
                begin
                    attacks_next[s2_sq_reg[d][k]] = 1'b1;
                end
            end
        end
        case (s2_cmd_reg)
            cpag_pkg::CMD_KNIGHT: attacks_next = cpag_pkg::leap_board(s2_square_reg, 1'b1);
            cpag_pkg::CMD_KING:   attacks_next = cpag_pkg::leap_board(s2_square_reg, 1'b0);
            default:              attacks_next = attacks_next;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            s3_cmd_reg    <= s2_cmd_reg;
            s3_square_reg <= s2_square_reg;
            attacks_reg   <= attacks_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign attacks   = attacks_reg;

    `ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, s1_valid_reg)
    `ASSERT_SAME(a_unused_code_empty, out_valid && (s3_cmd_reg > cpag_pkg::CMD_KING),
                 attacks == 64'd0)
    `ASSERT_SAME(a_own_square_clear, out_valid, !attacks[s3_square_reg])

endmodule

`default_nettype wire

/* sim/chess_piece_attack_generator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chess_piece_attack_generator_top_tb
// Self-checking bench for the attack generator. A driver feeds requests from
// a queue with random gaps, and a receiver stalls the output at random. Every
// accepted request is predicted by walking rays and leaper steps square by
// square. Each accepted result is compared in order with the prediction.
// ----------------------------------------------------------------------------

module chess_piece_attack_generator_top_tb;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         RANDOM_CHUNKS = 6;
    localparam int         CHUNK_REQS    = 255;
    localparam int         BURST_CYCLES  = 64;
    localparam logic [63:0] FULL_BOARD   = {64{1'b1}};

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  sq;
        logic [63:0] occ;
    } piece_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = '0;
    logic [5:0]  square = '0;
    logic [63:0] occupancy = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] attacks;

    piece_req_t  pending_reqs[$];
    logic [63:0] expected_boards[$];
    int          drv_issued = 0;
    int          req_accepted = 0;
    int          res_count = 0;
    int          mismatch_count = 0;
    int          tx_gap = 0;
    int          rx_wait = 0;
    int          rx_seen = 0;
    int          burst_req = 0;
    int          burst_ack = 0;
    int          burst_left = 0;
    logic        tx_idle = 1'b0;
    logic        rx_idle = 1'b0;

    chess_piece_attack_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .square    (square),
        .occupancy (occupancy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .attacks   (attacks)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Sliders walk each ray until the edge or the first occupied square.
    // Leapers take a single step in each of their directions.
    function automatic logic [63:0] piece_attacks(input logic [2:0] kind,
                                                  input logic [5:0] sq,
                                                  input logic [63:0] occ);
        logic [63:0] board;
        logic        take;
        logic        unit;
        logic        slide;
        int          adf;
        int          adr;
        int          f;
        int          r;
        board = '0;
        slide = (kind == cpag_pkg::CMD_BISHOP || kind == cpag_pkg::CMD_ROOK ||
                 kind == cpag_pkg::CMD_QUEEN);
        for (int df = -2; df <= 2; df++)
        begin
            for (int dr = -2; dr <= 2; dr++)
            begin
                adf = (df < 0) ? -df : df;
                adr = (dr < 0) ? -dr : dr;
                unit = (adf <= 1) && (adr <= 1) && (adf + adr > 0);
                case (kind)
                    cpag_pkg::CMD_KNIGHT: take = (adf + adr == 3);
                    cpag_pkg::CMD_BISHOP: take = unit && (adf + adr == 2);
                    cpag_pkg::CMD_ROOK:   take = unit && (adf + adr == 1);
                    cpag_pkg::CMD_QUEEN, cpag_pkg::CMD_KING: take = unit;
                    default:              take = 1'b0;
                endcase
                if (take)
                begin
                    f = int'(sq[2:0]) + df;
                    r = int'(sq[5:3]) + dr;
                    while (f >= 0 && f <= 7 && r >= 0 && r <= 7)
                    begin
                        board[r * 8 + f] = 1'b1;
                        if (!slide || occ[r * 8 + f])
                            break;
                        f += df;
                        r += dr;
                    end
                end
            end
        end
        return board;
    endfunction

    function automatic int draw_wait(input logic idle);
        return idle ? int'($urandom_range(0, 4)) : 0;
    endfunction

    task automatic queue_req(input logic [2:0] kind, input logic [5:0] sq,
                             input logic [63:0] occ);
        piece_req_t req;
        req.kind = kind;
        req.sq = sq;
        req.occ = occ;
        pending_reqs.push_back(req);
    endtask

    task automatic queue_random_req();
        logic [2:0]  kind;
        logic [63:0] occ;
        if ($urandom_range(0, 19) == 0)
            kind = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        else
            kind = 3'($urandom_range(cpag_pkg::CMD_KNIGHT, cpag_pkg::CMD_KING));
        case ($urandom_range(0, 5))
            0: occ = {$urandom, $urandom};
            1: occ = {$urandom, $urandom} & {$urandom, $urandom};
            2: occ = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3: occ = {$urandom, $urandom} | {$urandom, $urandom};
            4: occ = $urandom_range(0, 1) ? FULL_BOARD : '0;
            default: occ = 64'd1 << $urandom_range(0, 63);
        endcase
        queue_req(kind, 6'($urandom_range(0, 63)), occ);
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_reqs.size() != 0 || req_accepted != drv_issued ||
               expected_boards.size() != 0);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%0s) at %0t: expected %016h, got %016h",
                     what, $realtime, want, got);
    endtask

    always @(negedge clk)
    begin
        logic       offer;
        piece_req_t nxt;
        if (rst_n)
        begin
            offer = in_valid && (req_accepted != drv_issued);
            if (!offer)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    cmd <= nxt.kind;
                    square <= nxt.sq;
                    occupancy <= nxt.occ;
                    drv_issued++;
                    tx_gap = draw_wait(tx_idle);
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    always @(negedge clk)
    begin
        if (res_count != rx_seen)
        begin
            rx_seen = res_count;
            rx_wait = draw_wait(rx_idle);
        end
        if (burst_ack != burst_req)
        begin
            burst_ack = burst_req;
            burst_left = BURST_CYCLES;
        end
        if (burst_left != 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (rx_wait != 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_boards.push_back(piece_attacks(cmd, square, occupancy));
                req_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                res_count++;
                if (expected_boards.size() == 0)
                begin
                    note_mismatch("unexpected result", '0, attacks);
                end
                else
                begin
                    want = expected_boards.pop_front();
                    if (attacks !== want)
                        note_mismatch("attacks", want, attacks);
                end
            end
        end
    end

    initial
    begin
        queue_req(cpag_pkg::CMD_KNIGHT, 6'd0, '0);
        queue_req(cpag_pkg::CMD_KNIGHT, 6'd63, FULL_BOARD);
        queue_req(cpag_pkg::CMD_KNIGHT, 6'd27, FULL_BOARD);
        queue_req(cpag_pkg::CMD_KNIGHT, 6'd56, 64'h5555_5555_5555_5555);
        queue_req(cpag_pkg::CMD_BISHOP, 6'd0, '0);
        queue_req(cpag_pkg::CMD_BISHOP, 6'd63, FULL_BOARD);
        queue_req(cpag_pkg::CMD_BISHOP, 6'd27, '0);
        queue_req(cpag_pkg::CMD_BISHOP, 6'd9, (64'd1 << 18) | (64'd1 << 27));
        queue_req(cpag_pkg::CMD_ROOK, 6'd7, '0);
        queue_req(cpag_pkg::CMD_ROOK, 6'd56, FULL_BOARD);
        queue_req(cpag_pkg::CMD_ROOK, 6'd36, 64'd1 << 36);
        queue_req(cpag_pkg::CMD_ROOK, 6'd0, (64'd1 << 7) | (64'd1 << 56));
        queue_req(cpag_pkg::CMD_QUEEN, 6'd27, '0);
        queue_req(cpag_pkg::CMD_QUEEN, 6'd0, FULL_BOARD);
        queue_req(cpag_pkg::CMD_QUEEN, 6'd35, {$urandom, $urandom});
        queue_req(cpag_pkg::CMD_QUEEN, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_req(cpag_pkg::CMD_KING, 6'd0, '0);
        queue_req(cpag_pkg::CMD_KING, 6'd63, '0);
        queue_req(cpag_pkg::CMD_KING, 6'd7, FULL_BOARD);
        queue_req(cpag_pkg::CMD_KING, 6'd28, {$urandom, $urandom});
        queue_req(CMD_SPARE_5, 6'd27, '0);
        queue_req(CMD_SPARE_6, 6'd0, FULL_BOARD);
        queue_req(CMD_SPARE_7, 6'd63, {$urandom, $urandom});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            tx_idle = (chunk == 1 || chunk == 3 || chunk == 5);
            rx_idle = (chunk == 2 || chunk == 3 || chunk == 5);
            for (int n = 0; n < CHUNK_REQS; n++)
                queue_random_req();
            if (chunk == 4)
                burst_req++;
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_boards.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
